### design/lcdfb_pkg.sv
// Shared types and constants for the page-addressed LCD frame buffer.
package lcdfb_pkg;

  // Request codes on the cmd field
  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_BLANK = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Panel command bytes sent at the head of each page
  localparam logic [7:0] PAGE_CMD   = 8'hB0;
  localparam logic [7:0] COL_LO_CMD = 8'h00;
  localparam logic [7:0] COL_HI_CMD = 8'h10;

  // Refresh phases before the data bytes of a page
  localparam int unsigned HEAD_BYTES = 3;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_READ
  } lcdfb_state_t;

  // Write-side control from the controller to the frame store
  typedef struct packed {
    logic       clear;
    logic       merge;
    logic       pix_on;
    logic [7:0] mask;
  } lcdfb_wr_ctl_t;

endpackage

### design/page_lcd_framebuffer_refresh.sv
// Top level: page-addressed monochrome LCD frame buffer with byte-serial refresh.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_ready  | cmd, pix_x, pix_y, pix_on
//  out     | out_valid / out_ready| out_byte, is_data, frame_end
//
// A pixel write reads the store in ST_IDLE and writes the merged byte back
// in ST_PIX; a data-byte tick reads the store in ST_IDLE and loads the read
// data in ST_READ; a command-byte tick loads its byte in ST_IDLE, and an
// ignored request stays there. Reset and blank clear all COLUMNS*PAGES
// store bytes (1024 at defaults), one store byte per cycle, with in_ready low.
// in_ready is also low while the output register holds an untaken byte.
module page_lcd_framebuffer_refresh #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] pix_x,
  input  logic [7:0] pix_y,
  input  logic       pix_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       frame_end
);
  import lcdfb_pkg::*;

  localparam int ROWS  = PAGES * 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int PHW   = $clog2(COLUMNS + HEAD_BYTES);

  lcdfb_state_t  state, state_next;
  lcdfb_wr_ctl_t ctl;

  logic [AW-1:0]  clr_addr;
  logic           clr_last;
  logic [PW-1:0]  page;
  logic [PHW-1:0] phase;
  logic           phase_is_data;
  logic           phase_last;
  logic           page_last;
  logic [AW-1:0]  ref_addr;
  logic           ref_fend;
  logic [7:0]     head_byte;

  logic           pix_ok;
  logic [8:0]     row_sum;
  logic [8:0]     row;
  logic [PW-1:0]  pix_page;
  logic [AW-1:0]  pix_addr;
  logic [7:0]     pix_mask;

  logic [AW-1:0]  pix_addr_q;
  logic [7:0]     pix_mask_q;
  logic           pix_on_q;
  logic           fend_q;

  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic [7:0]     rd_data;

  logic           accept;
  logic           load_head;
  logic           load_data;

  // Pixel decode: range check, rotated row, byte address and bit mask
  always_comb begin
    pix_ok   = (pix_x != 8'd0) && ({1'b0, pix_x} <= 9'(COLUMNS))
            && (pix_y != 8'd0) && ({1'b0, pix_y} <= 9'(ROWS));
    row_sum  = {1'b0, pix_y} - 9'd1 + 9'(ROWS / 2);
    row      = (row_sum >= 9'(ROWS)) ? (row_sum - 9'(ROWS)) : row_sum;
    pix_page = PW'(row >> 3);
    pix_addr = AW'(int'(pix_page) * COLUMNS + int'(pix_x) - 1);
    pix_mask = 8'd1 << row[2:0];
  end

  // Refresh position decode
  always_comb begin
    phase_is_data = phase >= PHW'(HEAD_BYTES);
    phase_last    = phase == PHW'(COLUMNS + HEAD_BYTES - 1);
    page_last     = page == PW'(PAGES - 1);
    ref_addr      = AW'(int'(page) * COLUMNS + int'(phase) - HEAD_BYTES);
    ref_fend      = phase_last && page_last;
    case (phase)
      PHW'(0):  head_byte = PAGE_CMD | 8'(page);
      PHW'(1):  head_byte = COL_LO_CMD;
      default:  head_byte = COL_HI_CMD;
    endcase
  end

  assign clr_last = clr_addr == AW'(DEPTH - 1);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = (state == ST_IDLE) && (!out_valid || out_ready);
    accept     = in_valid && in_ready;
    load_head  = 1'b0;
    load_data  = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PIXEL: if (pix_ok) state_next = ST_PIX;
            CMD_BLANK: state_next = ST_CLEAR;
            CMD_TICK: begin
              if (phase_is_data) begin
                state_next = ST_READ;
              end else begin
                load_head = 1'b1;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX: begin
        state_next = ST_IDLE;
      end
      ST_READ: begin
        load_data  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Store port control
  always_comb begin
    ctl.clear  = state == ST_CLEAR;
    ctl.merge  = state == ST_PIX;
    ctl.pix_on = pix_on_q;
    ctl.mask   = pix_mask_q;
    waddr      = (state == ST_CLEAR) ? clr_addr : pix_addr_q;
    raddr      = (cmd == CMD_TICK) ? ref_addr : pix_addr;
  end

  // Control counters: clear sweep and refresh position
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      page     <= '0;
      phase    <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
      end
      if (accept && cmd == CMD_BLANK) begin
        clr_addr <= '0;
        page     <= '0;
        phase    <= '0;
      end else if (accept && cmd == CMD_TICK) begin
        if (phase_last) begin
          phase <= '0;
          page  <= page_last ? '0 : page + PW'(1);
        end else begin
          phase <= phase + PHW'(1);
        end
      end
    end
  end

  // Request payload held for the following ST_PIX or ST_READ state
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_addr_q <= pix_addr;
      pix_mask_q <= pix_mask;
      pix_on_q   <= pix_on;
      fend_q     <= ref_fend;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_head || load_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_head) begin
      out_byte  <= head_byte;
      is_data   <= 1'b0;
      frame_end <= 1'b0;
    end else if (load_data) begin
      out_byte  <= rd_data;
      is_data   <= 1'b1;
      frame_end <= fend_q;
    end
  end

  lcdfb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .waddr   (waddr),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

endmodule

### design/lcdfb_store.sv
// Frame store memory with clear writes and read-modify-write pixel merge.
module lcdfb_store #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  lcdfb_pkg::lcdfb_wr_ctl_t ctl,
  input  logic [AW-1:0]           waddr,
  input  logic [AW-1:0]           raddr,
  output logic [7:0]              rd_data
);
  import lcdfb_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] merged;

  // Set or clear one bit of the byte read in the previous cycle
  always_comb begin
    if (ctl.pix_on) begin
      merged = rd_data | ctl.mask;
    end else begin
      merged = rd_data & ~ctl.mask;
    end
  end

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mem[waddr] <= 8'h00;
    end else if (ctl.merge) begin
      mem[waddr] <= merged;
    end
    rd_data <= mem[raddr];
  end

endmodule

### tb/sv/page_lcd_framebuffer_refresh_test.sv
// Self-checking testbench for the page-addressed LCD frame buffer refresh block.
module page_lcd_framebuffer_refresh_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdfb_pkg::*;

  localparam int COLUMNS = 128;
  localparam int PAGES = 8;
  localparam int ROWS = PAGES * 8;
  localparam int RANDOM_REQUESTS = 1950;
  localparam int BLANK_AFTER = 1600;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT = 400;
  localparam int DRAIN_CYCLES = 16;

  // cmd code with no function; the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic       pix_on;
  } lcd_request_t;

  typedef struct {
    logic [7:0] value;
    logic       is_data;
    logic       frame_end;
  } panel_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = CMD_PIXEL;
  logic [7:0] pix_x = 8'd0;
  logic [7:0] pix_y = 8'd0;
  logic       pix_on = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_end;

  lcd_request_t queued_requests[$];
  panel_byte_t  expected_bytes[$];

  // Mirror of the frame store and refresh position
  logic [7:0] frame_mirror[COLUMNS*PAGES];
  int         scan_page;
  int         scan_phase;

  int n_errors = 0;
  int n_bytes_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  page_lcd_framebuffer_refresh #(
    .COLUMNS(COLUMNS),
    .PAGES(PAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .pix_x(pix_x),
    .pix_y(pix_y),
    .pix_on(pix_on),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .is_data(is_data),
    .frame_end(frame_end)
  );

  function automatic bit pixel_in_range(logic [7:0] x, logic [7:0] y);
    return x >= 1 && x <= COLUMNS && y >= 1 && y <= ROWS;
  endfunction

  // Apply one accepted request to the mirror; a refresh tick yields one panel byte
  task automatic model_request(lcd_request_t r);
    int row;
    int col;
    panel_byte_t b;
    case (r.cmd)
      CMD_PIXEL: begin
        if (pixel_in_range(r.pix_x, r.pix_y)) begin
          row = (int'(r.pix_y) - 1 + ROWS / 2) % ROWS;
          frame_mirror[(row / 8) * COLUMNS + int'(r.pix_x) - 1][row % 8] = r.pix_on;
        end
      end
      CMD_BLANK: begin
        foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
        scan_page = 0;
        scan_phase = 0;
      end
      CMD_TICK: begin
        b.is_data = 1'b0;
        b.frame_end = 1'b0;
        if (scan_phase == 0) begin
          b.value = PAGE_CMD | 8'(scan_page);
        end else if (scan_phase == 1) begin
          b.value = COL_LO_CMD;
        end else if (scan_phase == 2) begin
          b.value = COL_HI_CMD;
        end else begin
          col = scan_phase - HEAD_BYTES;
          b.value = frame_mirror[scan_page * COLUMNS + col];
          b.is_data = 1'b1;
          b.frame_end = (col == COLUMNS - 1) && (scan_page == PAGES - 1);
        end
        scan_phase++;
        if (scan_phase >= COLUMNS + HEAD_BYTES) begin
          scan_phase = 0;
          scan_page = (scan_page + 1) % PAGES;
        end
        expected_bytes.push_back(b);
      end
      default: ;
    endcase
  endtask

  task automatic add_request(logic [1:0] c, logic [7:0] x, logic [7:0] y, logic on);
    lcd_request_t r;
    r.cmd = c;
    r.pix_x = x;
    r.pix_y = y;
    r.pix_on = on;
    queued_requests.push_back(r);
  endtask

  // Driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    lcd_request_t r;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        r.cmd = cmd;
        r.pix_x = pix_x;
        r.pix_y = pix_y;
        r.pix_on = pix_on;
        model_request(r);
        if (burst_left > 0) burst_left--;
      end
      // hold the current request until it is taken
      if (!(in_valid && !in_ready)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          r = queued_requests.pop_front();
          in_valid <= 1'b1;
          cmd <= r.cmd;
          pix_x <= r.pix_x;
          pix_y <= r.pix_y;
          pix_on <= r.pix_on;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each panel byte and drive the receiver stall pattern
  always @(posedge clk) begin
    panel_byte_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_bytes_seen++;
        if (expected_bytes.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected byte %02h is_data %0b frame_end %0b",
                   $time, out_byte, is_data, frame_end);
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.value) begin
            n_errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, e.value, out_byte);
          end
          if (is_data !== e.is_data) begin
            n_errors++;
            $display("%0t: is_data expected %0b actual %0b", $time, e.is_data, is_data);
          end
          if (frame_end !== e.frame_end) begin
            n_errors++;
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, e.frame_end, frame_end);
          end
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 120);
      end else begin
        stall_mode_left--;
      end
      // one long hold-off so the output fills and the input backs up
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_bytes_seen >= HOLD_OFF_AT) begin
        hold_done = 1;
        hold_left = HOLD_OFF_CYCLES;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("page_lcd_framebuffer_refresh test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_effective;
    int pick;
    logic [7:0] x;
    logic [7:0] y;

    foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
    scan_page = 0;
    scan_phase = 0;

    // directed: head commands and first data bytes after reset
    repeat (5) add_request(CMD_TICK, 8'd0, 8'd0, 1'b0);
    // pixel corners and the row wrap at half height
    add_request(CMD_PIXEL, 8'd1, 8'd1, 1'b1);
    add_request(CMD_PIXEL, 8'd128, 8'd64, 1'b1);
    add_request(CMD_PIXEL, 8'd64, 8'd32, 1'b1);
    add_request(CMD_PIXEL, 8'd7, 8'd33, 1'b1);
    add_request(CMD_PIXEL, 8'd1, 8'd1, 1'b0);
    // out-of-range writes are dropped
    add_request(CMD_PIXEL, 8'd0, 8'd10, 1'b1);
    add_request(CMD_PIXEL, 8'd129, 8'd10, 1'b1);
    add_request(CMD_PIXEL, 8'd10, 8'd0, 1'b1);
    add_request(CMD_PIXEL, 8'd10, 8'd65, 1'b1);
    add_request(CMD_PIXEL, 8'd255, 8'd255, 1'b1);
    // unused command code
    add_request(CMD_UNUSED, 8'd255, 8'd255, 1'b1);
    repeat (2) add_request(CMD_TICK, 8'd0, 8'd0, 1'b0);
    // blank clears the store and restarts the page scan
    add_request(CMD_BLANK, 8'd0, 8'd0, 1'b0);
    add_request(CMD_PIXEL, 8'd1, 8'd33, 1'b1);
    add_request(CMD_PIXEL, 8'd2, 8'd40, 1'b1);
    repeat (5) add_request(CMD_TICK, 8'd0, 8'd0, 1'b0);

    // random: mostly ticks and in-range writes, blanks only late so full frames go out
    n_effective = 0;
    while (n_effective < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 999);
      if (pick < 700) begin
        add_request(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
        n_effective++;
      end else if (pick < 930) begin
        add_request(CMD_PIXEL, 8'($urandom_range(1, COLUMNS)), 8'($urandom_range(1, ROWS)),
                    1'($urandom));
        n_effective++;
      end else if (pick < 960) begin
        x = 8'($urandom);
        y = 8'($urandom);
        add_request(CMD_PIXEL, x, y, 1'($urandom));
        if (pixel_in_range(x, y)) n_effective++;
      end else if (pick < 980) begin
        add_request(CMD_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (n_effective > BLANK_AFTER && pick < 986) begin
        add_request(CMD_BLANK, 8'($urandom), 8'($urandom), 1'($urandom));
        n_effective++;
      end else begin
        add_request(CMD_TICK, 8'd0, 8'd0, 1'b0);
        n_effective++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge so driver updates have settled
    @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0 && expected_bytes.size() == 0) begin
      $display("page_lcd_framebuffer_refresh test passed");
    end else begin
      $display("page_lcd_framebuffer_refresh test failed");
    end
    $finish;
  end

endmodule
